### sv/ogg_first_page_validator_core_macros.svh
// Assertion macros shared by the checker of the first-page validator.
`ifndef OGG_FIRST_PAGE_VALIDATOR_CORE_MACROS_SVH
`define OGG_FIRST_PAGE_VALIDATOR_CORE_MACROS_SVH

// Implication check: when the antecedent holds, the consequent must follow.
`define OFPV_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when the antecedent holds, the consequent holds in the next cycle.
`define OFPV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ofpv_pkg.sv
// Types, constants and the CRC byte update of the first-page validator.
package ofpv_pkg;

    localparam logic [31:0] CRC_POLY  = 32'h04C11DB7;
    localparam int          HDR_LEN   = 27;
    localparam int          CRC_FIRST = 22;
    localparam int          CRC_LAST  = 25;
    localparam int          SEG_POS   = 26;
    localparam int          VER_POS   = 4;
    localparam int          FLAG_POS  = 5;
    localparam logic [7:0]  FLAG_BOS  = 8'h02;
    localparam logic [7:0]  FLAG_CONT = 8'h01;

    localparam logic [7:0] CAPTURE [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

    // Input modes
    localparam logic [1:0] MODE_DATA    = 2'd0;
    localparam logic [1:0] MODE_EOF     = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_EOF     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Verdict reasons
    localparam logic [3:0] RSN_OK      = 4'd0;
    localparam logic [3:0] RSN_SHORT   = 4'd1;
    localparam logic [3:0] RSN_CAPTURE = 4'd2;
    localparam logic [3:0] RSN_VERSION = 4'd3;
    localparam logic [3:0] RSN_NO_BOS  = 4'd4;
    localparam logic [3:0] RSN_CONT    = 4'd5;
    localparam logic [3:0] RSN_NO_SEG  = 4'd6;
    localparam logic [3:0] RSN_EMPTY   = 4'd7;
    localparam logic [3:0] RSN_CRC     = 4'd8;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic       page_valid;
        logic [3:0] fail_reason;
    } res_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++)
        begin
            r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

### sv/ofpv_front.sv
// Front end: classifies each input request into a command for the back end.
module ofpv_front
    import ofpv_pkg::*;
(
    input  item_t item,
    input  logic  accept,
    output logic  cmd_push,
    output cmd_t  cmd
);

    always_comb
    begin
        cmd.data = item.data_byte;
        cmd.kind = CMD_DATA;
        cmd_push = 1'b0;
        case (item.mode)
            MODE_DATA:
            begin
                cmd.kind = CMD_DATA;
                cmd_push = accept;
            end
            MODE_EOF:
            begin
                cmd.kind = CMD_EOF;
                cmd_push = accept;
            end
            MODE_RESTART:
            begin
                cmd.kind = CMD_RESTART;
                cmd_push = accept;
            end
            // unused mode: drop the request
            default:
            begin
                cmd.kind = CMD_DATA;
                cmd_push = 1'b0;
            end
        endcase
    end

endmodule

### sv/ofpv_cmd_queue.sv
// Short command queue between the front and back ends.
module ofpv_cmd_queue
    import ofpv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic valid,
    output cmd_t rd_cmd
);

    cmd_t                 mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0]   count_reg, count_next;

    assign full   = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign valid  = (count_reg != '0);
    assign rd_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + CMDQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CMDQ_CW'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - CMDQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

### sv/ofpv_back.sv
// Back end: page parsing, CRC accumulation and the verdict register.
module ofpv_back
    import ofpv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_take,
    output logic empty,
    input  logic pop,
    output res_t result
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SEGTAB = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [1:0]  phase_reg,  phase_next;
    logic [7:0]  pos_reg,    pos_next;
    logic [3:0]  status_reg, status_next;
    logic [7:0]  segcnt_reg, segcnt_next;
    logic [15:0] body_reg,   body_next;
    logic [31:0] crc_reg,    crc_next;
    logic [31:0] stored_reg, stored_next;
    logic        res_valid_reg, res_valid_next;
    res_t        res_reg,    res_next;

    logic        emit;
    logic [3:0]  reason;
    logic        in_crc_field;
    logic [7:0]  crc_in;
    logic [31:0] crc_upd;
    logic [15:0] body_sum;
    logic [7:0]  pos_inc;

    // advance only when the verdict slot is free or being drained
    assign cmd_take = cmd_valid && (!res_valid_reg || pop);
    assign empty    = !res_valid_reg;
    assign result   = res_reg;

    always_comb
    begin
        in_crc_field = (phase_reg == PH_HEADER) && (pos_reg inside {[CRC_FIRST:CRC_LAST]});
        crc_in       = in_crc_field ? 8'h00 : cmd.data;
        crc_upd      = crc_byte(crc_reg, crc_in);
        body_sum     = body_reg + {8'h00, cmd.data};
        pos_inc      = pos_reg + 8'd1;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        segcnt_next = segcnt_reg;
        body_next   = body_reg;
        crc_next    = crc_reg;
        stored_next = stored_reg;
        emit        = 1'b0;
        reason      = RSN_OK;

        if (cmd_take)
        begin
            case (cmd.kind)
                CMD_RESTART:
                begin
                    phase_next  = PH_HEADER;
                    pos_next    = '0;
                    status_next = RSN_OK;
                    segcnt_next = '0;
                    body_next   = '0;
                    crc_next    = '0;
                    stored_next = '0;
                end
                CMD_EOF:
                begin
                    if (phase_reg != PH_DONE)
                    begin
                        emit       = 1'b1;
                        reason     = RSN_SHORT;
                        phase_next = PH_DONE;
                    end
                end
                CMD_DATA:
                begin
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            crc_next = crc_upd;
                            // keep only the first fault in byte order
                            if (status_reg == RSN_OK)
                            begin
                                if (pos_reg < 8'(VER_POS))
                                begin
                                    if (cmd.data != CAPTURE[pos_reg[1:0]])
                                    begin
                                        status_next = RSN_CAPTURE;
                                    end
                                end
                                else if (pos_reg == 8'(VER_POS))
                                begin
                                    if (cmd.data != 8'h00)
                                    begin
                                        status_next = RSN_VERSION;
                                    end
                                end
                                else if (pos_reg == 8'(FLAG_POS))
                                begin
                                    if ((cmd.data & FLAG_BOS) == 8'h00)
                                    begin
                                        status_next = RSN_NO_BOS;
                                    end
                                    else if ((cmd.data & FLAG_CONT) != 8'h00)
                                    begin
                                        status_next = RSN_CONT;
                                    end
                                end
                                else if (pos_reg == 8'(SEG_POS) && cmd.data == 8'h00)
                                begin
                                    status_next = RSN_NO_SEG;
                                end
                            end
                            case (pos_reg)
                                8'(CRC_FIRST):     stored_next[7:0]   = cmd.data;
                                8'(CRC_FIRST + 1): stored_next[15:8]  = cmd.data;
                                8'(CRC_FIRST + 2): stored_next[23:16] = cmd.data;
                                8'(CRC_LAST):      stored_next[31:24] = cmd.data;
                                8'(SEG_POS):       segcnt_next        = cmd.data;
                                default:           ;
                            endcase
                            if (pos_reg == 8'(HDR_LEN - 1))
                            begin
                                if (status_next != RSN_OK)
                                begin
                                    emit       = 1'b1;
                                    reason     = status_next;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_SEGTAB;
                                    pos_next   = '0;
                                    body_next  = '0;
                                end
                            end
                            else
                            begin
                                pos_next = pos_inc;
                            end
                        end
                        PH_SEGTAB:
                        begin
                            crc_next  = crc_upd;
                            body_next = body_sum;
                            pos_next  = pos_inc;
                            if (pos_inc == segcnt_reg)
                            begin
                                if (body_sum == 16'h0000)
                                begin
                                    emit       = 1'b1;
                                    reason     = RSN_EMPTY;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_BODY;
                                end
                            end
                        end
                        PH_BODY:
                        begin
                            crc_next  = crc_upd;
                            body_next = body_reg - 16'd1;
                            if (body_reg == 16'd1)
                            begin
                                emit       = 1'b1;
                                reason     = (crc_upd == stored_reg) ? RSN_OK : RSN_CRC;
                                phase_next = PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (emit)
        begin
            res_valid_next       = 1'b1;
            res_next.page_valid  = (reason == RSN_OK);
            res_next.fail_reason = reason;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            status_reg    <= RSN_OK;
            segcnt_reg    <= '0;
            body_reg      <= '0;
            crc_reg       <= '0;
            stored_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            status_reg    <= status_next;
            segcnt_reg    <= segcnt_next;
            body_reg      <= body_next;
            crc_reg       <= crc_next;
            stored_reg    <= stored_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

### sv/ogg_first_page_validator_core.sv
// A byte request is first written into the command queue; a verdict is on the result
// ports in the cycle after its deciding byte is processed. Throughput: one request per
// cycle while the queue is not full, set by the byte-wide CRC update in the back end;
// a four-entry command queue lets input continue while a verdict waits to be popped.
// Reset: rst_n clears the queue, the parser state and the verdict slot at once.
module ogg_first_page_validator_core
    import ofpv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item,
    output logic  empty,
    input  logic  pop,
    output res_t  result
);

    logic cmd_push;
    cmd_t cmd_in;
    logic q_valid;
    cmd_t q_cmd;
    logic q_take;

    ofpv_front u_front (
        .item     (item),
        .accept   (push && !full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    ofpv_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd_in),
        .full   (full),
        .rd_en  (q_take),
        .valid  (q_valid),
        .rd_cmd (q_cmd)
    );

    ofpv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_take  (q_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### sv/ofpv_checker.sv
// Port-level checker for the first-page validator and its bind.
`include "ogg_first_page_validator_core_macros.svh"

module ofpv_checker
    import ofpv_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  full,
    input logic  empty,
    input logic  pop,
    input res_t  result
);

    logic valid_ok;
    logic reason_ok;
    logic waiting;

    assign valid_ok  = (result.page_valid == (result.fail_reason == RSN_OK));
    assign reason_ok = (result.fail_reason <= RSN_CRC);
    assign waiting   = !empty && !pop;

    `OFPV_ASSERT_IMPL(a_valid_reason, clk, rst_n, !empty, valid_ok, "page_valid mismatch")
    `OFPV_ASSERT_IMPL(a_reason_range, clk, rst_n, !empty, reason_ok, "fail_reason out of range")
    `OFPV_ASSERT_NEXT(a_held, clk, rst_n, waiting, !empty && $stable(result), "result moved")
    // the queue only backs up behind a verdict that nobody takes
    `OFPV_ASSERT_IMPL(a_full_held, clk, rst_n, full, !empty, "full without a waiting result")

endmodule

bind ogg_first_page_validator_core ofpv_checker u_ofpv_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
